// File: hw/rtl/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg: shared types for the fence tracked slot pool
// Slot and request codes, channel payloads and sequencer states.
// ----------------------------------------------------------------------------
package fts_pkg;

  typedef enum logic [2:0] {
    SLOT_EMPTY       = 3'd0,
    SLOT_READY       = 3'd1,
    SLOT_RECORDED    = 3'd2,
    SLOT_SUBMITTED   = 3'd3,
    SLOT_RETIRED     = 3'd4,
    SLOT_QUARANTINED = 3'd5
  } slot_state_t;

  typedef enum logic [2:0] {
    REQ_SERVICE    = 3'd0,
    REQ_RECORD     = 3'd1,
    REQ_SUBMIT     = 3'd2,
    REQ_CANCEL     = 3'd3,
    REQ_QUARANTINE = 3'd4
  } req_type_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOST,
    S_SCAN,
    S_ONE,
    S_RESP
  } seq_state_t;

  localparam logic [63:0] FENCE_LOST = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] device_id;
    logic [63:0] completed_value;
    logic [3:0]  slot_index;
    logic [63:0] fence_target;
    logic        copy_ok;
    logic        close_failed;
    logic [7:0]  driver_fail_mask;
  } req_t;

  typedef struct packed {
    logic       success;
    logic [2:0] granted_slot;
    logic [3:0] ready_slots;
  } rsp_t;

  typedef struct packed {
    slot_state_t state;
    logic [63:0] fence;
  } slot_entry_t;

endpackage

// File: hw/rtl/fts_if.sv
// ----------------------------------------------------------------------------
// fts_if: request and response channels of the slot pool
// Valid/ready channels carrying one payload struct each.
// ----------------------------------------------------------------------------
interface fts_req_if;
  import fts_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fts_rsp_if;
  import fts_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/fts_ram.sv
// ----------------------------------------------------------------------------
// fts_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// File: hw/rtl/fence_tracked_slot_pool.sv
// ----------------------------------------------------------------------------
// fence_tracked_slot_pool: pool of command slots tracked against a fence
// Service, record, submit, cancel and quarantine requests move slots through
// their life; every request answers with one response.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one request per transfer (valid/ready); taken only while idle.
//   out_rsp : one response per request (valid/ready), held in an output
//             register so the next request can start while it waits.
//   Slot state and fence sit in one memory with one write port and one read
//   port; a small sequencer walks it one slot per cycle.
//   A service scans every slot and a lost device sweeps every slot into
//   quarantine; a record scans up to the first ready slot; submit, cancel
//   and quarantine touch one slot; a rejected or ignored request goes
//   straight to its response.
//   The next request is taken the cycle after its predecessor's response is
//   loaded into the output register.
//   Reset clears all slots to empty (per-slot valid bits), unbinds the device
//   and the ready count. A stalled receiver holds the response; one more
//   request may then run up to its response and wait there.
// ----------------------------------------------------------------------------
module fence_tracked_slot_pool #(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  fts_req_if.sink   in_req,
  fts_rsp_if.source out_rsp
);
  import fts_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = $bits(slot_entry_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // Sequencer and request context
  seq_state_t      state_r, state_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [63:0]     done_r, done_nxt;
  logic [63:0]     target_r, target_nxt;
  logic            close_r, close_nxt;
  logic [7:0]      mask_r, mask_nxt;

  // Architectural state outside the memory
  logic [15:0]     bound_r, bound_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;

  // Result being built and the output register
  logic            success_r, success_nxt;
  logic [2:0]      granted_r, granted_nxt;
  logic            out_valid_r, out_valid_nxt;
  rsp_t            out_data_r, out_data_nxt;

  // Memory port
  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  slot_entry_t     ram_wdata, ram_rdata;
  logic [EW-1:0]   ram_rdata_raw;

  // Request decode
  logic            acc;
  logic            dev_bad, lost, rec_ok, in_range, single_op;
  logic            is_last, resp_load;
  slot_state_t     cur_state, new_state;
  logic            fail_bit;
  logic [6:0]      idx7;

  fts_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = slot_entry_t'(ram_rdata_raw);

  assign acc      = in_req.valid && in_req.ready;
  assign dev_bad  = (in_req.data.device_id == 16'd0) ||
                    ((bound_r != 16'd0) && (bound_r != in_req.data.device_id));
  assign lost     = (in_req.data.completed_value == FENCE_LOST);
  // Ready count tracked alongside the slots gives the no-ready-slot case early
  assign rec_ok   = in_req.data.copy_ok && (bound_r != 16'd0) && (cnt_r != '0);
  assign in_range = (7'(in_req.data.slot_index) < 7'(SLOTS));
  assign single_op = (in_req.data.req_type == REQ_SUBMIT) ||
                     (in_req.data.req_type == REQ_CANCEL) ||
                     (in_req.data.req_type == REQ_QUARANTINE);
  assign is_last  = (idx_r == LAST_IDX);
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_rsp.ready);

  // A slot never written since reset reads as empty
  assign cur_state = valid_r[idx_r] ? ram_rdata.state : SLOT_EMPTY;
  assign idx7      = 7'(idx_r);
  // Only the first eight slots have a driver-fail bit
  assign fail_bit  = (idx7 < 7'd8) && mask_r[idx7[2:0]];

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_req.data.req_type)
            REQ_SERVICE: begin
              if (dev_bad) state_nxt = S_RESP;
              else if (lost) state_nxt = S_LOST;
              else state_nxt = S_SCAN;
            end
            REQ_RECORD: state_nxt = rec_ok ? S_SCAN : S_RESP;
            REQ_SUBMIT, REQ_CANCEL, REQ_QUARANTINE: begin
              state_nxt = in_range ? S_ONE : S_RESP;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_LOST: begin
        if (is_last) state_nxt = S_RESP;
      end
      S_SCAN: begin
        if (is_last || ((op_r == REQ_RECORD) && (cur_state == SLOT_READY))) begin
          state_nxt = S_RESP;
        end
      end
      S_ONE: state_nxt = S_RESP;
      S_RESP: begin
        if (resp_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    done_nxt    = done_r;
    target_nxt  = target_r;
    close_nxt   = close_r;
    mask_nxt    = mask_r;
    bound_nxt   = bound_r;
    cnt_nxt     = cnt_r;
    valid_nxt   = valid_r;
    success_nxt = success_r;
    granted_nxt = granted_r;
    new_state   = cur_state;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_raddr   = IW'(idx_r + 1'b1);
    ram_wdata.state = cur_state;
    ram_wdata.fence = target_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt      = in_req.data.req_type;
          done_nxt    = in_req.data.completed_value;
          target_nxt  = in_req.data.fence_target;
          close_nxt   = in_req.data.close_failed;
          mask_nxt    = in_req.data.driver_fail_mask;
          success_nxt = 1'b0;
          granted_nxt = 3'd0;
          idx_nxt     = single_op ? IW'(in_req.data.slot_index) : '0;
          ram_raddr   = idx_nxt;
          if ((in_req.data.req_type == REQ_SERVICE) && !dev_bad) begin
            // Restart the ready count; the scan counts every slot left ready
            cnt_nxt = '0;
            if (!lost) begin
              bound_nxt = in_req.data.device_id;
            end
          end
        end
      end
      S_LOST: begin
        // Sweep every slot into quarantine
        ram_we          = 1'b1;
        ram_wdata.state = SLOT_QUARANTINED;
        idx_nxt         = IW'(idx_r + 1'b1);
      end
      S_SCAN: begin
        if (op_r == REQ_SERVICE) begin
          if ((cur_state == SLOT_SUBMITTED) && (ram_rdata.fence <= done_r)) begin
            new_state = SLOT_RETIRED;
          end
          if ((new_state == SLOT_RETIRED) || (new_state == SLOT_EMPTY)) begin
            new_state = fail_bit ? SLOT_QUARANTINED : SLOT_READY;
          end
          ram_we          = 1'b1;
          ram_wdata.state = new_state;
          // Hold the fence of a slot still in flight, clear the rest
          ram_wdata.fence = (new_state == SLOT_SUBMITTED) ? ram_rdata.fence : 64'd0;
          if (new_state == SLOT_READY) cnt_nxt = cnt_r + CW'(1);
          if (is_last) success_nxt = (cnt_nxt != '0);
          idx_nxt = IW'(idx_r + 1'b1);
        end else begin
          // Claim the lowest ready slot; a failed close quarantines it instead
          if (cur_state == SLOT_READY) begin
            ram_we          = 1'b1;
            ram_wdata.state = close_r ? SLOT_QUARANTINED : SLOT_RECORDED;
            cnt_nxt         = cnt_r - CW'(1);
            success_nxt     = !close_r;
            granted_nxt     = close_r ? 3'd0 : 3'(idx_r);
          end else begin
            idx_nxt = IW'(idx_r + 1'b1);
          end
        end
      end
      S_ONE: begin
        case (op_r)
          REQ_SUBMIT: begin
            if ((cur_state == SLOT_RECORDED) && (target_r != 64'd0) &&
                (target_r != FENCE_LOST)) begin
              new_state = SLOT_SUBMITTED;
            end else begin
              new_state = SLOT_QUARANTINED;
            end
          end
          REQ_CANCEL: begin
            if (cur_state == SLOT_RECORDED) new_state = SLOT_RETIRED;
            else if (cur_state == SLOT_SUBMITTED) new_state = SLOT_QUARANTINED;
          end
          default: new_state = SLOT_QUARANTINED;
        endcase
        ram_we          = 1'b1;
        ram_wdata.state = new_state;
        // None of these moves lands in ready; drop one when a ready slot moves
        if ((cur_state == SLOT_READY) && (new_state != SLOT_READY)) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
      end
    endcase

    if (ram_we) valid_nxt[ram_waddr] = 1'b1;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_rsp.ready) out_valid_nxt = 1'b0;
    if (resp_load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.success      = success_r;
      out_data_nxt.granted_slot = granted_r;
      out_data_nxt.ready_slots  =
        ({{(32 - CW){1'b0}}, cnt_r} > 32'd15) ? 4'd15 : 4'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bound_r     <= 16'd0;
      cnt_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bound_r     <= bound_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    done_r     <= done_nxt;
    target_r   <= target_nxt;
    close_r    <= close_nxt;
    mask_r     <= mask_nxt;
    success_r  <= success_nxt;
    granted_r  <= granted_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for fence_tracked_slot_pool
// Sends service, record, submit, cancel and quarantine requests over the
// request channel while a behavioral copy of the slot pool predicts every
// response. Each response is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fts_pkg::*;

  localparam int NUM_SLOTS    = 8;
  localparam int RANDOM_ITEMS = 1000;  // random requests, noise included
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = NUM_SLOTS + 4;
  localparam int LIVE_FLOOR   = 5;     // random traffic never drops below this

  // Request codes the block has no meaning for.
  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_DENSE} rx_mode_t;

  logic clk;
  logic rst_n;

  fts_req_if req_ch ();
  fts_rsp_if rsp_ch ();

  fence_tracked_slot_pool #(
    .SLOTS(NUM_SLOTS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  // --------------------------------------------------------------------------
  // Behavioral slot pool: state as the block should hold it after every
  // accepted request.
  // --------------------------------------------------------------------------
  slot_state_t pool_st [NUM_SLOTS];
  logic [63:0] pool_fence [NUM_SLOTS];
  logic [15:0] pool_dev;

  rsp_t        rsp_pending [$];    // responses owed by the block, oldest first
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  bit          hold_req     = 1'b0; // ask the receiver for a long hold-off
  logic [15:0] dev_id;              // device the stimulus binds

  // Clock: 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the pool and return the response it must produce.
  function automatic rsp_t pool_step(input req_t r);
    rsp_t        rsp;
    int unsigned nready;
    bit          served;
    bit          taken;
    rsp    = '0;
    nready = 0;
    served = 1'b0;
    taken  = 1'b0;
    case (r.req_type)
      REQ_SERVICE: begin
        // Reject a missing device or one that differs from the bound one.
        if (r.device_id != '0 && (pool_dev == '0 || pool_dev == r.device_id)) begin
          if (r.completed_value == FENCE_LOST) begin
            // Device lost: every slot is gone, nothing binds, success stays low.
            for (int i = 0; i < NUM_SLOTS; i++) pool_st[i] = SLOT_QUARANTINED;
          end else begin
            pool_dev = r.device_id;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (pool_st[i] == SLOT_SUBMITTED && pool_fence[i] <= r.completed_value)
                pool_st[i] = SLOT_RETIRED;
              if (pool_st[i] == SLOT_RETIRED) begin
                pool_fence[i] = '0;
                pool_st[i] = r.driver_fail_mask[i] ? SLOT_QUARANTINED : SLOT_READY;
              end else if (pool_st[i] == SLOT_EMPTY) begin
                pool_st[i] = r.driver_fail_mask[i] ? SLOT_QUARANTINED : SLOT_READY;
              end
            end
            served = 1'b1;
          end
        end
      end
      REQ_RECORD: begin
        // Claim the lowest ready slot; a failed close loses it instead.
        if (r.copy_ok && pool_dev != '0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!taken && pool_st[i] == SLOT_READY) begin
              taken = 1'b1;
              if (r.close_failed) begin
                pool_st[i] = SLOT_QUARANTINED;
              end else begin
                pool_st[i] = SLOT_RECORDED;
                rsp.success = 1'b1;
                rsp.granted_slot = 3'(i);
              end
            end
          end
        end
      end
      REQ_SUBMIT: begin
        if (r.slot_index < NUM_SLOTS) begin
          if (pool_st[r.slot_index] != SLOT_RECORDED || r.fence_target == '0 ||
              r.fence_target == FENCE_LOST) begin
            pool_st[r.slot_index] = SLOT_QUARANTINED;
          end else begin
            pool_fence[r.slot_index] = r.fence_target;
            pool_st[r.slot_index] = SLOT_SUBMITTED;
          end
        end
      end
      REQ_CANCEL: begin
        if (r.slot_index < NUM_SLOTS) begin
          if (pool_st[r.slot_index] == SLOT_RECORDED)
            pool_st[r.slot_index] = SLOT_RETIRED;
          else if (pool_st[r.slot_index] == SLOT_SUBMITTED)
            pool_st[r.slot_index] = SLOT_QUARANTINED;
        end
      end
      REQ_QUARANTINE: begin
        if (r.slot_index < NUM_SLOTS) pool_st[r.slot_index] = SLOT_QUARANTINED;
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_SLOTS; i++) if (pool_st[i] == SLOT_READY) nready++;
    rsp.ready_slots = (nready > 15) ? 4'd15 : 4'(nready);
    if (served) rsp.success = (nready != 0);
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Every field random; callers overwrite the fields their request uses.
  function automatic req_t any_req();
    req_t r;
    r.req_type         = 3'($urandom_range(REQ_SERVICE, REQ_RSVD_LAST));
    r.device_id        = 16'($urandom);
    r.completed_value  = rand64();
    r.slot_index       = 4'($urandom);
    r.fence_target     = rand64();
    r.copy_ok          = 1'($urandom);
    r.close_failed     = 1'($urandom);
    r.driver_fail_mask = 8'($urandom);
    return r;
  endfunction

  function automatic req_t service_req(input logic [63:0] done, input logic [7:0] fails);
    req_t r;
    r = any_req();
    r.req_type         = REQ_SERVICE;
    r.device_id        = dev_id;
    r.completed_value  = done;
    r.driver_fail_mask = fails;
    return r;
  endfunction

  function automatic req_t record_req(input logic ok, input logic close_bad);
    req_t r;
    r = any_req();
    r.req_type     = REQ_RECORD;
    r.copy_ok      = ok;
    r.close_failed = close_bad;
    return r;
  endfunction

  function automatic req_t slot_req(input req_type_t t, input int idx,
                                    input logic [63:0] fence);
    req_t r;
    r = any_req();
    r.req_type     = t;
    r.slot_index   = 4'(idx);
    r.fence_target = fence;
    return r;
  endfunction

  // Random slot in the given state, or the fallback when there is none.
  function automatic int pick_slot(input slot_state_t s, input int fallback);
    int hits [$];
    for (int i = 0; i < NUM_SLOTS; i++) if (pool_st[i] == s) hits.push_back(i);
    if (hits.size() == 0) return fallback;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic int live_slots();
    int n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) if (pool_st[i] != SLOT_QUARANTINED) n++;
    return n;
  endfunction

  // Slots a service with this completed value would recycle; a driver-fail
  // bit on any of them would lose the slot.
  function automatic logic [7:0] exposed_mask(input logic [63:0] done);
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (pool_st[i] == SLOT_EMPTY || pool_st[i] == SLOT_RETIRED ||
          (pool_st[i] == SLOT_SUBMITTED && pool_fence[i] <= done))
        m[i] = 1'b1;
    return m;
  endfunction

  // Mix small values, so that fences and completions meet often, with full
  // 64-bit ones.
  function automatic logic [63:0] good_fence();
    logic [63:0] v;
    v = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(1, 4096)) : rand64();
    if (v == '0 || v == FENCE_LOST) v = 64'd1;
    return v;
  endfunction

  function automatic logic [63:0] done_value();
    logic [63:0] v;
    v = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 4096)) : rand64();
    if (v == FENCE_LOST) v = FENCE_LOST - 64'd1;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Call at a falling edge; returns at the falling edge after
  // the transfer with valid still high, so back-to-back requests keep valid
  // up. Anything that stops sending lowers valid first.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t r, input int unsigned gap);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_directed(input req_t r);
    send_req(r, $urandom_range(0, 4));
  endtask

  // Stop sending and wait until every owed response has come back.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (rsp_pending.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Before any device is bound: records fail, a zero device is refused,
  // unknown codes and out-of-range slots do nothing.
  task automatic test_unbound();
    req_t r;
    send_directed(record_req(1'b1, 1'b0));
    r = any_req();
    r.req_type  = REQ_SERVICE;
    r.device_id = '0;
    r.completed_value = '0;
    send_directed(r);
    r = any_req();
    r.req_type = REQ_RSVD_FIRST;
    send_directed(r);
    r.req_type = REQ_RSVD_LAST;
    send_directed(r);
    // every field at its top value; slot index is past the pool
    r = '1;
    r.req_type = REQ_QUARANTINE;
    send_directed(r);
  endtask

  // Bind a device, walk slots through record, submit, retire and cancel.
  task automatic test_bind_and_retire();
    req_t r;
    dev_id = 16'($urandom_range(1, 16'hFFFE));
    // first service: the top slot fails its creation
    send_directed(service_req(64'd0, 8'h80));
    r = service_req(64'd0, 8'h00);
    r.device_id = ~dev_id;
    send_directed(r);
    send_directed(record_req(1'b0, 1'($urandom)));
    // lowest ready slots are 0 and 1: one with the largest legal fence, one with 1
    send_directed(record_req(1'b1, 1'b0));
    send_directed(slot_req(REQ_SUBMIT, 0, FENCE_LOST - 64'd1));
    send_directed(record_req(1'b1, 1'b0));
    send_directed(slot_req(REQ_SUBMIT, 1, 64'd1));
    // nothing retires at zero, so a full fail mask touches no recycled slot
    send_directed(service_req(64'd0, 8'hFF));
    send_directed(service_req(64'd1, 8'h00));
    // cancel a recorded slot, cancel it again while retired, then recycle it
    send_directed(record_req(1'b1, 1'b0));
    send_directed(slot_req(REQ_CANCEL, 1, rand64()));
    send_directed(slot_req(REQ_CANCEL, 1, rand64()));
    send_directed(service_req(64'd0, 8'h00));
  endtask

  // Mostly well-formed traffic with random content; a share of noise and, while
  // enough slots survive, the odd request that loses a slot.
  task automatic test_random_traffic();
    req_t        r;
    int          s;
    int          pick;
    int          useful;
    int unsigned burst_left;
    int unsigned gap;
    bit          held;
    bit          paused;
    logic [63:0] done;
    useful     = 0;
    burst_left = 0;
    held       = 1'b0;
    paused     = 1'b0;
    while (useful < RANDOM_ITEMS) begin
      // Hold the receiver off while requests keep coming, so the block backs up.
      if (!held && useful >= RANDOM_ITEMS / 3) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      // Pause the sender once until the pool has answered everything.
      if (!paused && useful >= 2 * RANDOM_ITEMS / 3) begin
        paused = 1'b1;
        wait_idle();
      end
      pick  = $urandom_range(0, 99);
      if (pick < 30) begin
        done = done_value();
        r = service_req(done, 8'($urandom) & ~exposed_mask(done));
      end else if (pick < 55) begin
        r = record_req(1'b1, 1'b0);
      end else if (pick < 75) begin
        s = pick_slot(SLOT_RECORDED, -1);
        r = (s < 0) ? record_req(1'b1, 1'b0) : slot_req(REQ_SUBMIT, s, good_fence());
      end else if (pick < 83) begin
        // cancel a recorded slot, or one whose state cancel leaves alone
        s = pick_slot(SLOT_RECORDED, -1);
        if (s < 0) s = pick_slot(SLOT_READY, -1);
        if (s < 0) s = pick_slot(SLOT_QUARANTINED, NUM_SLOTS);
        r = slot_req(REQ_CANCEL, s, rand64());
      end else if (pick < 99 || live_slots() <= LIVE_FLOOR) begin
        r = any_req();
        case ($urandom_range(0, 3))
          0: r.req_type = 3'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
          1: begin
            r.req_type   = 3'($urandom_range(REQ_SUBMIT, REQ_QUARANTINE));
            r.slot_index = 4'($urandom_range(NUM_SLOTS, 15));
          end
          2: begin
            // wrong or missing device, sometimes claiming the device is lost
            r.req_type = REQ_SERVICE;
            if (r.device_id == dev_id) r.device_id = '0;
            if ($urandom_range(0, 1) != 0) r.completed_value = FENCE_LOST;
          end
          default: begin
            r.req_type = REQ_RECORD;
            r.copy_ok  = 1'b0;
          end
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: r = record_req(1'b1, 1'b1);
          1: r = slot_req(REQ_QUARANTINE, $urandom_range(0, NUM_SLOTS - 1), rand64());
          default: begin
            s = pick_slot(SLOT_SUBMITTED, -1);
            if (s >= 0)
              r = slot_req(REQ_CANCEL, s, rand64());
            else
              r = slot_req(REQ_SUBMIT, $urandom_range(0, NUM_SLOTS - 1), '0);
          end
        endcase
      end
      useful++;
      // Bursts of back-to-back requests separated by random gaps.
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 24);
      end else begin
        gap = 0;
      end
      burst_left--;
      send_req(r, gap);
    end
  endtask

  // Ways a single slot gets lost through record, submit, cancel and quarantine.
  task automatic test_slot_loss();
    send_directed(record_req(1'b1, 1'b1));
    // submit on a ready slot that is not recorded
    send_directed(slot_req(REQ_SUBMIT, pick_slot(SLOT_READY, 0), good_fence()));
    send_directed(record_req(1'b1, 1'b0));
    send_directed(slot_req(REQ_SUBMIT, pick_slot(SLOT_RECORDED, 0), 64'd0));
    send_directed(record_req(1'b1, 1'b0));
    send_directed(slot_req(REQ_SUBMIT, pick_slot(SLOT_RECORDED, 0), FENCE_LOST));
    // cancel after submit loses the slot
    send_directed(slot_req(REQ_CANCEL, pick_slot(SLOT_SUBMITTED, 0), rand64()));
    send_directed(slot_req(REQ_QUARANTINE, pick_slot(SLOT_READY, 0), rand64()));
  endtask

  // Device lost: the whole pool is quarantined and stays dead.
  task automatic test_device_lost();
    send_directed(service_req(FENCE_LOST, 8'($urandom)));
    send_directed(service_req(64'd0, 8'h00));
    send_directed(record_req(1'b1, 1'b0));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n        = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    dev_id       = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pool_st[i]    = SLOT_EMPTY;
      pool_fence[i] = '0;
    end
    pool_dev = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_unbound();
    test_bind_and_retire();
    test_random_traffic();
    wait_idle();
    test_slot_loss();
    test_device_lost();

    // Drain, then keep watching so that any stray response shows.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response receiver: random stall modes in runs, including runs with no
  // stall at all, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : rsp_sink
    rx_mode_t    mode;
    int unsigned run_left;
    int unsigned phase;
    rsp_ch.ready = 1'b0;
    mode     = RX_STREAM;
    run_left = 0;
    phase    = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (run_left == 0) begin
        mode = rx_mode_t'($urandom_range(RX_STREAM, RX_DENSE));
        run_left = $urandom_range(16, 160);
      end
      run_left--;
      phase++;
      case (mode)
        RX_STREAM: rsp_ch.ready <= 1'b1;
        RX_COIN:   rsp_ch.ready <= 1'($urandom);
        RX_SPARSE: rsp_ch.ready <= (phase % 4 == 0);
        default:   rsp_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each request transfer, check on each response
  // transfer, and watch for a stalled run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    rsp_t got;
    bit   req_xfer;
    bit   rsp_xfer;
    req_xfer = rst_n && req_ch.valid && req_ch.ready;
    rsp_xfer = rst_n && rsp_ch.valid && rsp_ch.ready;
    // A response never leaves in the cycle its request is taken, so
    // predicting first is safe.
    if (req_xfer) rsp_pending.push_back(pool_step(req_ch.data));
    if (rsp_xfer) begin
      got = rsp_ch.data;
      if (rsp_pending.size() == 0) begin
        $error("response with none owed: success %0d granted_slot %0d ready_slots %0d",
               got.success, got.granted_slot, got.ready_slots);
        mismatches++;
      end else begin
        want = rsp_pending.pop_front();
        if (got.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, got.success);
          mismatches++;
        end
        if (got.granted_slot !== want.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", want.granted_slot, got.granted_slot);
          mismatches++;
        end
        if (got.ready_slots !== want.ready_slots) begin
          $error("ready_slots: expected %0d, got %0d", want.ready_slots, got.ready_slots);
          mismatches++;
        end
      end
    end
    // Watchdog: too long without any transfer means the block is stuck.
    if (req_xfer || rsp_xfer) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles, %0d responses outstanding",
             quiet_cycles, rsp_pending.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule

// File: fence_tracked_slot_pool.f
hw/rtl/fts_pkg.sv
hw/rtl/fts_if.sv
hw/rtl/fts_ram.sv
hw/rtl/fence_tracked_slot_pool.sv
dv/tb_top.sv
